@@ rtl/core/pgmd_pkg.sv @@
// ----------------------------------------------------------------------------
// pgmd_pkg
// Shared types, register indexes, status codes and saturating adders for the
// particle grid moment deposit block.
// ----------------------------------------------------------------------------
`default_nettype none

package pgmd_pkg;

  // Configuration register indexes.
  localparam logic [1:0] REG_CELLS   = 2'd0;
  localparam logic [1:0] REG_SPACING = 2'd1;
  localparam logic [1:0] REG_INVERSE = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_DEPOSIT = 2'd0;
  localparam logic [1:0] ST_DROP    = 2'd1;
  localparam logic [1:0] ST_READ    = 2'd2;

  // Field widths.
  localparam int POS_W  = 19;
  localparam int LOC_W  = 6;
  localparam int DLT_W  = 23;
  localparam int PRD_W  = 46;
  localparam int CFG_W  = 22;

  // One cell's accumulators, stored as one memory word.
  typedef struct packed {
    logic signed [23:0] count;
    logic signed [47:0] dx;
    logic signed [47:0] dy;
    logic signed [47:0] dz;
    logic signed [63:0] dxx;
    logic signed [63:0] dyy;
    logic signed [63:0] dzz;
    logic signed [63:0] dxy;
    logic signed [63:0] dxz;
    logic signed [63:0] dyz;
  } acc_t;

  // Count accumulator: add or subtract one, clamped to 24 bits.
  function automatic logic signed [23:0] sat24(logic signed [23:0] acc, logic sub);
    logic signed [24:0] s;
    s = sub ? 25'(acc) - 25'sd1 : 25'(acc) + 25'sd1;
    if (s[24] != s[23]) begin
      return s[24] ? {1'b1, 23'b0} : {1'b0, {23{1'b1}}};
    end
    return s[23:0];
  endfunction

  // First moment accumulator, clamped to 48 bits.
  function automatic logic signed [47:0] sat48(logic signed [47:0] acc,
                                               logic signed [DLT_W-1:0] d, logic sub);
    logic signed [48:0] dd;
    logic signed [48:0] s;
    dd = sub ? -49'(d) : 49'(d);
    s  = 49'(acc) + dd;
    if (s[48] != s[47]) begin
      return s[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
    end
    return s[47:0];
  endfunction

  // Second moment accumulator, clamped to 64 bits.
  function automatic logic signed [63:0] sat64(logic signed [63:0] acc,
                                               logic signed [PRD_W-1:0] d, logic sub);
    logic signed [64:0] dd;
    logic signed [64:0] s;
    dd = sub ? -65'(d) : 65'(d);
    s  = 65'(acc) + dd;
    if (s[64] != s[63]) begin
      return s[64] ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
    end
    return s[63:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/particle_grid_moment_deposit.sv @@
// ----------------------------------------------------------------------------
// particle_grid_moment_deposit
// Nearest-grid-point deposit of particles with count, first and second
// moment accumulators per cell of a cubic grid.
// ----------------------------------------------------------------------------
// After reset the block sweeps its accumulator memory to zero, one cell per
// cycle, GRID_SIZE**3 cells in all (32768 at the default); no request is
// taken during the sweep, configuration writes are. Each request is then
// handled on its own, and no new one is taken before its result reaches the
// output register: a deposit goes through the position multiplies, rounding,
// offset, moment products with the cell address, registered memory read and
// saturating write back; a read goes through the memory read alone; a
// deposit that falls outside the grid is dropped after the offset, and a read
// beyond the store is dropped at once. The result sits in an output register,
// so a new request is taken while the previous result still waits; a request
// whose result finds that register still full waits in its last step.
`default_nettype none

module particle_grid_moment_deposit #(
  parameter int GRID_SIZE = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // Configuration port.
  input  wire logic                 cfg_we,
  input  wire logic [1:0]           cfg_index,
  input  wire logic [pgmd_pkg::CFG_W-1:0] cfg_data,
  // Request channel.
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 func,
  input  wire logic                 negative_particle,
  input  wire logic [18:0]          pos_x,
  input  wire logic [18:0]          pos_y,
  input  wire logic [18:0]          pos_z,
  input  wire logic [14:0]          read_cell,
  // Result channel.
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic signed [23:0]        out_count,
  output logic signed [47:0]        out_dx,
  output logic signed [47:0]        out_dy,
  output logic signed [47:0]        out_dz,
  output logic signed [63:0]        out_dxx,
  output logic signed [63:0]        out_dyy,
  output logic signed [63:0]        out_dzz,
  output logic signed [63:0]        out_dxy,
  output logic signed [63:0]        out_dxz,
  output logic signed [63:0]        out_dyz
);
  import pgmd_pkg::*;

  localparam int DEPTH = GRID_SIZE * GRID_SIZE * GRID_SIZE;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_LOC   = 4'd3;
  localparam logic [3:0] S_DELTA = 4'd4;
  localparam logic [3:0] S_PROD  = 4'd5;
  localparam logic [3:0] S_ADDR  = 4'd6;
  localparam logic [3:0] S_READ  = 4'd7;
  localparam logic [3:0] S_UPD   = 4'd8;
  localparam logic [3:0] S_DROP  = 4'd9;

  logic [3:0]              state;
  logic [5:0]              cells_per_axis;
  logic [15:0]             grid_spacing;
  logic [21:0]             inverse_spacing;
  logic [6:0]              n_eff;

  logic                    is_read;
  logic                    neg;
  logic [POS_W-1:0]        pos [3];
  logic [40:0]             prod [3];
  logic [LOC_W-1:0]        loc [3];
  logic                    bad;
  logic signed [DLT_W-1:0] dlt [3];
  logic signed [PRD_W-1:0] pxx, pyy, pzz, pxy, pxz, pyz;
  logic [AW-1:0]           row;
  logic [AW-1:0]           rd_addr;
  logic [AW-1:0]           clr_addr;
  acc_t                    mem [DEPTH];
  acc_t                    rd_data;
  acc_t                    upd;
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr;
  acc_t                    mem_wdata;
  logic                    out_free;
  logic                    read_ok;
  logic [LOC_W-1:0]        loc_next [3];
  logic                    bad_next;
  logic signed [DLT_W-1:0] dlt_next [3];

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);
  assign read_ok  = 32'(read_cell) < DEPTH;

  // Cells per axis as used: zero counts as one, large values clamp to the grid.
  always_comb begin
    if (cells_per_axis == 6'd0) begin
      n_eff = 7'd1;
    end else if (32'(cells_per_axis) > GRID_SIZE) begin
      n_eff = 7'(GRID_SIZE);
    end else begin
      n_eff = {1'b0, cells_per_axis};
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cells_per_axis  <= 6'd32;
      grid_spacing    <= 16'd12868;
      inverse_spacing <= 22'd333772;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CELLS:   cells_per_axis  <= cfg_data[5:0];
        REG_SPACING: grid_spacing    <= cfg_data[15:0];
        REG_INVERSE: inverse_spacing <= cfg_data;
        default: ;
      endcase
    end
  end

  // Rounding to the nearest cell, with the top index stepped back by one.
  always_comb begin
    logic [41:0] r;
    logic [9:0]  l;
    bad_next = 1'b0;
    for (int a = 0; a < 3; a++) begin
      r = 42'(prod[a]) + 42'h0_8000_0000;
      l = r[41:32];
      if (l >= 10'(n_eff)) begin
        l = l - 10'd1;
      end
      if (l >= 10'(n_eff)) begin
        bad_next = 1'b1;
      end
      loc_next[a] = l[LOC_W-1:0];
    end
  end

  // Offset of each coordinate from its cell point.
  always_comb begin
    logic [21:0] m;
    for (int a = 0; a < 3; a++) begin
      m = {16'b0, loc[a]} * {6'b0, grid_spacing};
      dlt_next[a] = $signed({4'b0, pos[a]}) - $signed({1'b0, m});
    end
  end

  // Saturating update of the cell that was read.
  always_comb begin
    upd.count = sat24(rd_data.count, neg);
    upd.dx    = sat48(rd_data.dx, dlt[0], neg);
    upd.dy    = sat48(rd_data.dy, dlt[1], neg);
    upd.dz    = sat48(rd_data.dz, dlt[2], neg);
    upd.dxx   = sat64(rd_data.dxx, pxx, neg);
    upd.dyy   = sat64(rd_data.dyy, pyy, neg);
    upd.dzz   = sat64(rd_data.dzz, pzz, neg);
    upd.dxy   = sat64(rd_data.dxy, pxy, neg);
    upd.dxz   = sat64(rd_data.dxz, pxz, neg);
    upd.dyz   = sat64(rd_data.dyz, pyz, neg);
  end

  // Memory write selection: clearing sweep or deposit write back.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = rd_addr;
    mem_wdata = upd;
    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_addr;
      mem_wdata = '0;
    end else if (state == S_UPD && !is_read && out_free) begin
      mem_we = 1'b1;
    end
  end

  // Accumulator memory with a registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= mem[rd_addr];
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          is_read <= func;
          neg     <= negative_particle;
          pos[0]  <= pos_x;
          pos[1]  <= pos_y;
          pos[2]  <= pos_z;
          rd_addr <= AW'(read_cell);
        end
      end
      S_MUL: begin
        for (int a = 0; a < 3; a++) begin
          prod[a] <= 41'(pos[a]) * 41'(inverse_spacing);
        end
      end
      S_LOC: begin
        loc <= loc_next;
        bad <= bad_next;
      end
      S_DELTA: begin
        dlt <= dlt_next;
        row <= AW'(loc[1]) + AW'(n_eff) * AW'(loc[0]);
      end
      S_PROD: begin
        pxx     <= PRD_W'(dlt[0]) * PRD_W'(dlt[0]);
        pyy     <= PRD_W'(dlt[1]) * PRD_W'(dlt[1]);
        pzz     <= PRD_W'(dlt[2]) * PRD_W'(dlt[2]);
        pxy     <= PRD_W'(dlt[0]) * PRD_W'(dlt[1]);
        pxz     <= PRD_W'(dlt[0]) * PRD_W'(dlt[2]);
        pyz     <= PRD_W'(dlt[1]) * PRD_W'(dlt[2]);
        rd_addr <= AW'(loc[2]) + AW'(n_eff) * row;
      end
      default: ;
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (32'(clr_addr) == DEPTH - 1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            if (!func) begin
              state <= S_MUL;
            end else if (read_ok) begin
              state <= S_READ;
            end else begin
              state <= S_DROP;
            end
          end
        end
        S_MUL:   state <= S_LOC;
        S_LOC:   state <= S_DELTA;
        S_DELTA: state <= bad ? S_DROP : S_PROD;
        S_PROD:  state <= S_READ;
        S_READ:  state <= S_UPD;
        S_UPD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_DROP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= (state == S_UPD) || (state == S_DROP);
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && (state == S_UPD || state == S_DROP)) begin
      if (state == S_UPD && is_read) begin
        status    <= ST_READ;
        out_count <= rd_data.count;
        out_dx    <= rd_data.dx;
        out_dy    <= rd_data.dy;
        out_dz    <= rd_data.dz;
        out_dxx   <= rd_data.dxx;
        out_dyy   <= rd_data.dyy;
        out_dzz   <= rd_data.dzz;
        out_dxy   <= rd_data.dxy;
        out_dxz   <= rd_data.dxz;
        out_dyz   <= rd_data.dyz;
      end else begin
        status    <= (state == S_DROP) ? ST_DROP : ST_DEPOSIT;
        out_count <= '0;
        out_dx    <= '0;
        out_dy    <= '0;
        out_dz    <= '0;
        out_dxx   <= '0;
        out_dyy   <= '0;
        out_dzz   <= '0;
        out_dxy   <= '0;
        out_dxz   <= '0;
        out_dyz   <= '0;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pgmd_check.sv @@
// ----------------------------------------------------------------------------
// pgmd_check
// Port-level checks for the particle grid moment deposit block.
// ----------------------------------------------------------------------------
`default_nettype none

module pgmd_check (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [1:0]         status,
  input wire logic signed [23:0] out_count,
  input wire logic signed [63:0] out_dxx
);
  import pgmd_pkg::*;

  // A held result stays valid.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // A held result keeps its status.
  a_status_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(status))
    else $error("result status changed while stalled");

  // Only a read carries sums, and no unused status code appears.
  a_zero_sums: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_READ |->
      (status == ST_DEPOSIT || status == ST_DROP) && out_count == 0 && out_dxx == 0)
    else $error("deposit or drop result carries sums");

  // One request at a time: the block stalls right after taking one.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

endmodule

bind particle_grid_moment_deposit pgmd_check u_pgmd_check (.*);

`default_nettype wire
